// File: rtl/pdr_pkg.sv
package pdr_pkg;

    localparam int PDR_DUTY_MAX = 1000;
    localparam int PDR_ADC_BITS = 12;

    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 3;
    localparam int WORD_W    = 64;
    localparam int MUL_B_W   = 20;
    localparam int DIV_W     = 34;
    localparam int CNT_W     = 6;
    localparam int E_W       = 42;
    localparam int ES_W      = 43;
    localparam int S_W       = 56;
    localparam int T_W       = 44;
    localparam int DUTY_O_W  = 10;
    localparam int MV_W      = 16;

    localparam logic [DIV_W-1:0] FULL_SCALE_MUV = 34'd12000000000;
    localparam logic [WORD_W-1:0] TERM_LIM      = 64'd4398046511104;
    localparam logic [MV_W-1:0] MV_SAT           = 16'hFFFF;
    localparam logic [DIV_W-1:0] UV_PER_MV       = 34'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KP      = 3'd0,
        REG_KI      = 3'd1,
        REG_KD      = 3'd2,
        REG_SP      = 3'd3,
        REG_STEP    = 3'd4,
        REG_PERIOD  = 3'd5,
        REG_INIT    = 3'd6,
        REG_ENABLE  = 3'd7
    } t_reg_idx;

    typedef enum logic {
        OP_MUL = 1'b0,
        OP_DIV = 1'b1
    } t_op;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_arith_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_arith_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MEAS,
        S_MV,
        S_INT,
        S_ITERM,
        S_DMUL,
        S_DDIV,
        S_INNER,
        S_DRIVE,
        S_SCALE,
        S_DIV,
        S_DONE
    } t_state;

endpackage

// File: rtl/pdr_arith.sv
module pdr_arith (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  pdr_pkg::t_arith_req        i_req,
    input  logic [pdr_pkg::WORD_W-1:0] i_a,
    input  logic [pdr_pkg::DIV_W-1:0]  i_b,
    output pdr_pkg::t_arith_rsp        o_rsp,
    output logic [pdr_pkg::WORD_W-1:0] o_result
);
    import pdr_pkg::*;

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    t_op               r_op, n_op;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [WORD_W-1:0] r_acc, n_acc;
    logic [WORD_W-1:0] r_a, n_a;
    logic [DIV_W-1:0]  r_b, n_b;
    logic [DIV_W-1:0]  r_rem, n_rem;
    logic [DIV_W:0]    trial;
    logic              ge;

    always_comb begin
        trial = {r_rem, r_acc[WORD_W-1]};
        ge    = trial >= {1'b0, r_b};
        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_a    = r_a;
        n_b    = r_b;
        n_rem  = r_rem;
        if (i_req.start && !r_busy) begin
            n_busy = 1'b1;
            n_op   = i_req.op;
            n_b    = i_b;
            n_rem  = '0;
            n_a    = i_a;
            if (i_req.op == OP_MUL) begin
                n_acc = '0;
                n_cnt = CNT_W'(MUL_B_W - 1);
            end else begin
                n_acc = i_a;
                n_cnt = CNT_W'(WORD_W - 1);
            end
        end else if (r_busy) begin
            case (r_op)
                OP_MUL: begin
                    if (r_b[0]) n_acc = r_acc + r_a;
                    n_a = {r_a[WORD_W-2:0], 1'b0};
                    n_b = {1'b0, r_b[DIV_W-1:1]};
                end
                OP_DIV: begin
                    n_rem = ge ? DIV_W'(trial - {1'b0, r_b}) : trial[DIV_W-1:0];
                    n_acc = {r_acc[WORD_W-2:0], ge};
                end
                default: n_acc = r_acc;
            endcase
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_op  <= n_op;
        r_cnt <= n_cnt;
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
        r_rem <= n_rem;
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_result   = r_acc;

endmodule

// File: rtl/pid_duty_regulator.sv
// Channel  Direction  Handshake                 Word
// input    in         i_in_valid / o_in_stall   i_adc_sample
// result   out        o_out_valid / i_out_stall o_duty, o_sample_mv
// config   in         i_cfg_we                  i_cfg_addr, i_cfg_data
//
// For an enabled sample one shared shift-add multiplier / restoring divider runs 5
// multiplies, each over the low 20 bits of the multiplier operand, and 4 divides, plus
// the sum, the hand-off and idle. Full duty, zero ki or a non-positive sum skip steps.
// A disabled sample goes from idle straight to the done state.
// Reset is synchronous, active low, and clears state.
// A stalled result holds in the output register; the next sample is taken meanwhile.
module pid_duty_regulator #(
    parameter int DUTY_MAX = pdr_pkg::PDR_DUTY_MAX,
    parameter int ADC_BITS = pdr_pkg::PDR_ADC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pdr_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [pdr_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [ADC_BITS-1:0]           i_adc_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [pdr_pkg::DUTY_O_W-1:0]  o_duty,
    output logic [pdr_pkg::MV_W-1:0]      o_sample_mv
);
    import pdr_pkg::*;

    localparam int DW = $clog2(DUTY_MAX + 1);
    localparam logic [DW-1:0] DUTY_TOP = DW'(DUTY_MAX);
    localparam int MEAS_W = ADC_BITS + 16;

    logic [19:0] r_kp, r_ki, r_kd;
    logic [15:0] r_sp, r_step;
    logic [9:0]  r_per, r_init;
    logic        r_en;

    t_state r_state, n_state;
    logic   r_go;

    logic [ADC_BITS-1:0]   r_sample;
    logic [MEAS_W-1:0]     r_meas;
    logic signed [E_W-1:0] r_e, r_prev;
    logic signed [ES_W-1:0] r_esum, r_de;
    logic signed [S_W-1:0] r_s;
    logic signed [T_W-1:0] r_iterm, r_dterm, r_inner;
    logic [WORD_W-1:0]     r_prod;
    logic [DW-1:0]         r_duty;
    logic [MV_W-1:0]       r_mv;
    logic                  r_fresh;

    logic                  r_out_valid;
    logic [DW-1:0]         r_out_duty;
    logic [MV_W-1:0]       r_out_mv;

    t_arith_req        req;
    t_arith_rsp        rsp;
    logic [WORD_W-1:0] op_a, res;
    logic [DIV_W-1:0]  op_b;

    logic [9:0]             per_eff;
    logic [DW-1:0]          init_sat;
    logic signed [E_W-1:0]  e_new;
    logic signed [S_W:0]    s_sum;
    logic [WORD_W-1:0]      q_mag;
    logic signed [T_W-1:0]  q_signed;
    logic signed [T_W+1:0]  inner_sum;
    logic signed [T_W-1:0]  inner_clamped;
    logic                   out_free;
    logic [DW+DUTY_O_W-1:0] duty_ext;

    pdr_arith u_arith (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (req),
        .i_a      (op_a),
        .i_b      (op_b),
        .o_rsp    (rsp),
        .o_result (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp   <= 20'd1000;
            r_ki   <= 20'd1000;
            r_kd   <= '0;
            r_sp   <= '0;
            r_step <= 16'd806;
            r_per  <= 10'd2;
            r_init <= '0;
            r_en   <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_addr))
                REG_KP:     r_kp   <= i_cfg_data;
                REG_KI:     r_ki   <= i_cfg_data;
                REG_KD:     r_kd   <= i_cfg_data;
                REG_SP:     r_sp   <= i_cfg_data[15:0];
                REG_STEP:   r_step <= i_cfg_data[15:0];
                REG_PERIOD: r_per  <= i_cfg_data[9:0];
                REG_INIT:   r_init <= i_cfg_data[9:0];
                REG_ENABLE: r_en   <= i_cfg_data[0];
                default:    r_en   <= r_en;
            endcase
        end
    end

    assign per_eff  = (r_per == '0) ? 10'd1 : r_per;
    assign init_sat = (32'(r_init) > DUTY_MAX) ? DUTY_TOP : DW'(r_init);
    assign e_new    = $signed(E_W'(r_sp) * E_W'(1000)) - $signed(E_W'(r_meas));
    assign s_sum    = (r_esum < 0) ? ($signed({r_s[S_W-1], r_s}) - $signed(57'(res[52:0])))
                                   : ($signed({r_s[S_W-1], r_s}) + $signed(57'(res[52:0])));
    assign q_mag    = (res > TERM_LIM) ? TERM_LIM : res;
    assign inner_sum = (T_W+2)'(r_e) + (T_W+2)'(r_iterm) + (T_W+2)'(r_dterm);
    assign inner_clamped =
        (inner_sum > $signed((T_W+2)'(TERM_LIM))) ? $signed(T_W'(TERM_LIM)) :
        (inner_sum < -$signed((T_W+2)'(TERM_LIM))) ? -$signed(T_W'(TERM_LIM)) :
        inner_sum[T_W-1:0];
    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        q_signed = '0;
        case (r_state)
            S_ITERM: q_signed = r_s[S_W-1] ? -$signed(T_W'(q_mag)) : $signed(T_W'(q_mag));
            S_DDIV:  q_signed = r_de[ES_W-1] ? -$signed(T_W'(q_mag)) : $signed(T_W'(q_mag));
            default: q_signed = '0;
        endcase
    end

    always_comb begin
        op_a = '0;
        op_b = '0;
        req.op = OP_MUL;
        case (r_state)
            S_MEAS:  begin op_a = WORD_W'(r_sample); op_b = DIV_W'(r_step); end
            S_MV:    begin op_a = WORD_W'(r_meas); op_b = UV_PER_MV; req.op = OP_DIV; end
            S_INT:   begin
                op_a = WORD_W'(r_esum < 0 ? -r_esum : r_esum);
                op_b = DIV_W'(per_eff);
            end
            S_ITERM: begin
                op_a = WORD_W'(r_s < 0 ? -r_s : r_s);
                op_b = DIV_W'({r_ki, 1'b0});
                req.op = OP_DIV;
            end
            S_DMUL:  begin op_a = WORD_W'(r_de < 0 ? -r_de : r_de); op_b = DIV_W'(r_kd); end
            S_DDIV:  begin op_a = r_prod; op_b = DIV_W'(per_eff); req.op = OP_DIV; end
            S_DRIVE: begin op_a = WORD_W'(r_inner[T_W-2:0]); op_b = DIV_W'(r_kp); end
            S_SCALE: begin op_a = r_prod; op_b = DIV_W'(DUTY_MAX); end
            S_DIV:   begin op_a = r_prod; op_b = FULL_SCALE_MUV; req.op = OP_DIV; end
            default: op_a = '0;
        endcase
        req.start = r_go && (r_state != S_IDLE) && (r_state != S_INNER)
                    && (r_state != S_DONE);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = r_en ? S_MEAS : S_DONE;
            S_MEAS:  if (rsp.done) n_state = S_MV;
            S_MV:    if (rsp.done) begin
                if (r_duty != DUTY_TOP) n_state = S_INT;
                else n_state = (r_ki != '0) ? S_ITERM : S_DMUL;
            end
            S_INT:   if (rsp.done) n_state = (r_ki != '0) ? S_ITERM : S_DMUL;
            S_ITERM: if (rsp.done) n_state = S_DMUL;
            S_DMUL:  if (rsp.done) n_state = S_DDIV;
            S_DDIV:  if (rsp.done) n_state = S_INNER;
            S_INNER: n_state = (inner_sum > 0) ? S_DRIVE : S_DONE;
            S_DRIVE: if (rsp.done)
                n_state = (res >= WORD_W'(FULL_SCALE_MUV) || res == '0) ? S_DONE : S_SCALE;
            S_SCALE: if (rsp.done) n_state = S_DIV;
            S_DIV:   if (rsp.done) n_state = S_DONE;
            S_DONE:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_go        <= 1'b0;
            r_fresh     <= 1'b1;
            r_prev      <= '0;
            r_s         <= '0;
            r_duty      <= '0;
            r_mv        <= '0;
            r_iterm     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_go    <= (n_state != r_state) ? 1'b1 : (r_go && !req.start);
            r_out_valid <= (r_state == S_DONE && out_free) || (r_out_valid && i_out_stall);
            case (r_state)
                S_IDLE: if (i_in_valid && r_en && r_fresh) begin
                    r_duty  <= init_sat;
                    r_fresh <= 1'b0;
                end
                S_MV: if (rsp.done) begin
                    r_mv   <= (res > WORD_W'(MV_SAT)) ? MV_SAT : res[MV_W-1:0];
                    r_prev <= e_new;
                    if (r_ki == '0) r_iterm <= '0;
                end
                S_INT: if (rsp.done) begin
                    if (s_sum > $signed({2'b00, {(S_W-1){1'b1}}}))
                        r_s <= {1'b0, {(S_W-1){1'b1}}};
                    else if (s_sum < $signed({2'b11, {(S_W-1){1'b0}}}))
                        r_s <= {1'b1, {(S_W-1){1'b0}}};
                    else
                        r_s <= s_sum[S_W-1:0];
                end
                S_ITERM: if (rsp.done) r_iterm <= q_signed;
                S_INNER: if (inner_sum <= 0) r_duty <= '0;
                S_DRIVE: if (rsp.done) begin
                    if (res >= WORD_W'(FULL_SCALE_MUV)) r_duty <= DUTY_TOP;
                    else if (res == '0) r_duty <= '0;
                end
                S_DIV: if (rsp.done) r_duty <= DW'(res);
                default: r_s <= r_s;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE:  if (i_in_valid) r_sample <= i_adc_sample;
            S_MEAS:  if (rsp.done) r_meas <= res[MEAS_W-1:0];
            S_MV:    if (rsp.done) begin
                r_e    <= e_new;
                r_esum <= ES_W'(e_new) + ES_W'(r_prev);
                r_de   <= ES_W'(e_new) - ES_W'(r_prev);
            end
            S_DMUL:  if (rsp.done) r_prod <= res;
            S_DDIV:  if (rsp.done) r_dterm <= q_signed;
            S_INNER: r_inner <= inner_clamped;
            S_DRIVE: if (rsp.done) r_prod <= res;
            S_SCALE: if (rsp.done) r_prod <= res;
            S_DONE:  if (out_free) begin
                r_out_duty <= r_duty;
                r_out_mv   <= r_mv;
            end
            default: r_prod <= r_prod;
        endcase
    end

    assign duty_ext    = {{DUTY_O_W{1'b0}}, r_out_duty};
    assign o_duty      = duty_ext[DUTY_O_W-1:0];
    assign o_sample_mv = r_out_mv;
    assign o_out_valid = r_out_valid;
    assign o_in_stall  = (r_state != S_IDLE);

    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_in_stall)
        else $error("sample taken while a sample is in work");
    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(r_out_duty) <= DUTY_MAX))
        else $error("duty above full scale");
    a_unit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req.start |-> !rsp.busy)
        else $error("arithmetic unit started while busy");
    a_result_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> o_out_valid)
        else $error("finished word not presented");

endmodule
